[rtl/eipl4_pkg.sv]
// Shared types and constants for the Ethernet / IPv4 / L4 header parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package eipl4_pkg;

    // Protocol constants.
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  IP_VERSION_4   = 4'd4;
    localparam logic [3:0]  IHL_MASK       = 4'hf;

    // Header lengths in bytes.
    localparam logic [15:0] ETH_HDR_LEN = 16'd14;
    localparam logic [15:0] IP_MIN_HDR  = 16'd20;
    localparam logic [15:0] TCP_MIN_HDR = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN = 16'd8;

    // Fixed byte positions within the frame.
    localparam logic [15:0] POS_SRC_MAC  = 16'd6;
    localparam logic [15:0] POS_ETYPE    = 16'd12;
    localparam logic [15:0] POS_VIHL     = 16'd14;
    localparam logic [15:0] POS_TLEN_HI  = 16'd16;
    localparam logic [15:0] POS_TLEN_LO  = 16'd17;
    localparam logic [15:0] POS_PROTO    = 16'd23;
    localparam logic [15:0] POS_SRC_IP   = 16'd26;
    localparam logic [15:0] POS_DST_IP   = 16'd30;
    localparam logic [15:0] POS_L4_MIN   = 16'd34;
    localparam logic [15:0] CNT_MAX      = 16'hffff;

    // Offsets within the transport header.
    localparam logic [15:0] L4_DST_PORT  = 16'd2;
    localparam logic [15:0] L4_UDP_LEN   = 16'd4;
    localparam logic [15:0] L4_UDP_END   = 16'd6;
    localparam logic [15:0] L4_TCP_OFF   = 16'd12;

    // Status codes.
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_SHORT_ETH   = 4'd1;
    localparam logic [3:0] ST_SHORT_IP    = 4'd2;
    localparam logic [3:0] ST_BAD_VERSION = 4'd3;
    localparam logic [3:0] ST_BAD_IHL     = 4'd4;
    localparam logic [3:0] ST_TOTAL_SHORT = 4'd5;
    localparam logic [3:0] ST_SHORT_TCP   = 4'd6;
    localparam logic [3:0] ST_BAD_TCP_OFF = 4'd7;
    localparam logic [3:0] ST_TCP_PAST_IP = 4'd8;
    localparam logic [3:0] ST_SHORT_UDP   = 4'd9;
    localparam logic [3:0] ST_BAD_UDP_LEN = 4'd10;

    // Frame kinds.
    localparam logic [1:0] KIND_NON_IP = 2'd0;
    localparam logic [1:0] KIND_IP     = 2'd1;
    localparam logic [1:0] KIND_TCP    = 2'd2;
    localparam logic [1:0] KIND_UDP    = 2'd3;

    // Header fields of one complete frame, handed from capture to checking.
    typedef struct packed {
        logic [15:0] len;
        logic [47:0] dest_mac;
        logic [47:0] src_mac;
        logic [15:0] ether_kind;
        logic [7:0]  version_ihl;
        logic [15:0] total_len;
        logic [7:0]  protocol;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [3:0]  tcp_offset;
        logic [15:0] udp_len;
    } t_hdr_snap;

endpackage

`default_nettype wire

[rtl/eipl4_capture.sv]
// Byte-position capture of the Ethernet, IPv4 and TCP/UDP header fields.
// Depends on eipl4_pkg; hands a snapshot of each complete frame to eipl4_judge.
`default_nettype none

module eipl4_capture
    import eipl4_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_frame_byte,
    input  wire logic        i_end_of_frame,
    output logic             o_snap_vld,
    output t_hdr_snap        o_snap,
    input  wire logic        i_snap_take
);

    logic        r_svld;
    t_hdr_snap   r_snap;
    t_hdr_snap   r_st;
    t_hdr_snap   n_st;
    logic        w_acc;
    logic [15:0] w_pos;
    logic [6:0]  w_l4_start;
    logic [15:0] w_d;
    logic        w_in_l4;

    // A beat is taken unless a finished frame is waiting in the snapshot and is not being taken.
    assign o_in_ready = !r_svld || i_snap_take;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_pos      = r_st.len;

    // Start of the transport header: Ethernet header plus IHL words.
    assign w_l4_start = 7'(ETH_HDR_LEN) + {1'b0, r_st.version_ihl[3:0], 2'b00};
    assign w_in_l4    = (w_pos >= POS_L4_MIN) && (w_pos >= {9'd0, w_l4_start});
    assign w_d        = w_pos - {9'd0, w_l4_start};

    // Next header state after capturing the current byte.
    always_comb begin
        n_st = r_st;
        if (w_pos < POS_SRC_MAC) begin
            n_st.dest_mac = {r_st.dest_mac[39:0], i_frame_byte};
        end else if (w_pos < POS_ETYPE) begin
            n_st.src_mac = {r_st.src_mac[39:0], i_frame_byte};
        end else if (w_pos < POS_VIHL) begin
            n_st.ether_kind = {r_st.ether_kind[7:0], i_frame_byte};
        end else if (w_pos == POS_VIHL) begin
            n_st.version_ihl = i_frame_byte;
        end else if (w_pos == POS_TLEN_HI || w_pos == POS_TLEN_LO) begin
            n_st.total_len = {r_st.total_len[7:0], i_frame_byte};
        end else if (w_pos == POS_PROTO) begin
            n_st.protocol = i_frame_byte;
        end else if (w_pos >= POS_SRC_IP && w_pos < POS_DST_IP) begin
            n_st.src_ip = {r_st.src_ip[23:0], i_frame_byte};
        end else if (w_pos >= POS_DST_IP && w_pos < POS_L4_MIN) begin
            n_st.dst_ip = {r_st.dst_ip[23:0], i_frame_byte};
        end

        if (w_in_l4) begin
            if (w_d < L4_DST_PORT) begin
                n_st.src_port = {r_st.src_port[7:0], i_frame_byte};
            end else if (w_d < L4_UDP_LEN) begin
                n_st.dst_port = {r_st.dst_port[7:0], i_frame_byte};
            end else if (w_d < L4_UDP_END) begin
                n_st.udp_len = {r_st.udp_len[7:0], i_frame_byte};
            end else if (w_d == L4_TCP_OFF) begin
                n_st.tcp_offset = i_frame_byte[7:4];
            end
        end

        // The byte count saturates rather than wrapping.
        n_st.len = (w_pos < CNT_MAX) ? (w_pos + 16'd1) : CNT_MAX;
    end

    // Header state: cleared after every final beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (w_acc) begin
            if (i_end_of_frame) begin
                r_st <= '0;
            end else begin
                r_st <= n_st;
            end
        end
    end

    // Snapshot of the finished frame's headers.
    always_ff @(posedge i_clk) begin
        if (w_acc && i_end_of_frame) begin
            r_snap <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svld <= 1'b0;
        end else if (w_acc && i_end_of_frame) begin
            r_svld <= 1'b1;
        end else if (i_snap_take) begin
            r_svld <= 1'b0;
        end
    end

    assign o_snap_vld = r_svld;
    assign o_snap     = r_snap;

    // A final beat always restarts the byte count.
    a_cnt_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_end_of_frame) |=> (r_st.len == 16'd0))
        else $error("byte count not cleared after final beat");

    // A beat inside a frame always leaves a non-zero count.
    a_cnt_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_end_of_frame) |=> (r_st.len != 16'd0))
        else $error("byte count did not advance");

    // A waiting snapshot is never dropped before it is taken.
    a_snap_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_svld && !i_snap_take) |=> (r_svld && $stable(r_snap)))
        else $error("snapshot lost while waiting");

endmodule

`default_nettype wire

[rtl/eipl4_judge.sv]
// Header checks on a captured frame and the registered result beat.
// Depends on eipl4_pkg; fed by eipl4_capture.
`default_nettype none

module eipl4_judge
    import eipl4_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_snap_vld,
    input  wire t_hdr_snap   i_snap,
    output logic             o_snap_take,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_parse_status,
    output logic [1:0]       o_frame_kind,
    output logic [47:0]      o_dest_mac,
    output logic [47:0]      o_src_mac,
    output logic [15:0]      o_ether_kind,
    output logic [31:0]      o_src_ip,
    output logic [31:0]      o_dst_ip,
    output logic [7:0]       o_ip_protocol,
    output logic [15:0]      o_src_port,
    output logic [15:0]      o_dst_port,
    output logic [7:0]       o_payload_start,
    output logic [15:0]      o_payload_bytes
);

    logic        r_vld;
    logic [3:0]  r_status, n_status;
    logic [1:0]  r_kind, n_kind;
    logic [47:0] r_dmac, n_dmac;
    logic [47:0] r_smac, n_smac;
    logic [15:0] r_etype, n_etype;
    logic [31:0] r_sip, n_sip;
    logic [31:0] r_dip, n_dip;
    logic [7:0]  r_proto, n_proto;
    logic [15:0] r_sport, n_sport;
    logic [15:0] r_dport, n_dport;
    logic [7:0]  r_pstart, n_pstart;
    logic [15:0] r_pbytes, n_pbytes;

    logic [15:0] w_hl;
    logic [15:0] w_t;
    logic [15:0] w_avail;
    logic [15:0] w_endo;
    logic [15:0] w_tcp_hl;
    logic [15:0] w_tcp_end;
    logic [16:0] w_udp_end;

    // The result register frees when empty or when its beat is taken.
    assign o_snap_take = i_snap_vld && (!r_vld || i_out_ready);

    // Lengths derived from the captured header fields.
    assign w_hl      = {10'd0, i_snap.version_ihl[3:0] & IHL_MASK, 2'b00};
    assign w_t       = ETH_HDR_LEN + w_hl;
    assign w_avail   = i_snap.len - ETH_HDR_LEN;
    assign w_endo    = ETH_HDR_LEN +
                       ((i_snap.total_len <= w_avail) ? i_snap.total_len : w_avail);
    assign w_tcp_hl  = {10'd0, i_snap.tcp_offset, 2'b00};
    assign w_tcp_end = w_t + w_tcp_hl;
    assign w_udp_end = {1'b0, w_t} + {1'b0, i_snap.udp_len};

    // Checks in priority order; the first failure sets the status.
    always_comb begin
        n_status = ST_OK;
        n_kind   = KIND_NON_IP;
        n_dmac   = '0;
        n_smac   = '0;
        n_etype  = '0;
        n_sip    = '0;
        n_dip    = '0;
        n_proto  = '0;
        n_sport  = '0;
        n_dport  = '0;
        n_pstart = '0;
        n_pbytes = '0;
        if (i_snap.len < ETH_HDR_LEN) begin
            n_status = ST_SHORT_ETH;
        end else begin
            n_dmac  = i_snap.dest_mac;
            n_smac  = i_snap.src_mac;
            n_etype = i_snap.ether_kind;
            if (i_snap.ether_kind == ETHERTYPE_IPV4) begin
                n_kind = KIND_IP;
                if (i_snap.len < ETH_HDR_LEN + IP_MIN_HDR) begin
                    n_status = ST_SHORT_IP;
                end else if (i_snap.version_ihl[7:4] != IP_VERSION_4) begin
                    n_status = ST_BAD_VERSION;
                end else if (w_hl < IP_MIN_HDR || i_snap.len < w_t) begin
                    n_status = ST_BAD_IHL;
                end else if (i_snap.total_len < w_hl) begin
                    n_status = ST_TOTAL_SHORT;
                end else begin
                    n_sip   = i_snap.src_ip;
                    n_dip   = i_snap.dst_ip;
                    n_proto = i_snap.protocol;
                    if (i_snap.protocol == PROTO_TCP) begin
                        n_kind = KIND_TCP;
                        if (i_snap.len < w_t + TCP_MIN_HDR) begin
                            n_status = ST_SHORT_TCP;
                        end else if (w_tcp_hl < TCP_MIN_HDR || i_snap.len < w_tcp_end) begin
                            n_status = ST_BAD_TCP_OFF;
                        end else if (w_tcp_end > w_endo) begin
                            n_status = ST_TCP_PAST_IP;
                        end else begin
                            n_sport  = i_snap.src_port;
                            n_dport  = i_snap.dst_port;
                            n_pstart = w_tcp_end[7:0];
                            n_pbytes = w_endo - w_tcp_end;
                        end
                    end else if (i_snap.protocol == PROTO_UDP) begin
                        n_kind = KIND_UDP;
                        if (i_snap.len < w_t + UDP_HDR_LEN) begin
                            n_status = ST_SHORT_UDP;
                        end else if (i_snap.udp_len < UDP_HDR_LEN ||
                                     w_udp_end > {1'b0, w_endo}) begin
                            n_status = ST_BAD_UDP_LEN;
                        end else begin
                            n_sport  = i_snap.src_port;
                            n_dport  = i_snap.dst_port;
                            n_pstart = 8'(w_t + UDP_HDR_LEN);
                            n_pbytes = i_snap.udp_len - UDP_HDR_LEN;
                        end
                    end
                end
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_snap_take) begin
            r_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_vld <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_snap_take) begin
            r_status <= n_status;
            r_kind   <= n_kind;
            r_dmac   <= n_dmac;
            r_smac   <= n_smac;
            r_etype  <= n_etype;
            r_sip    <= n_sip;
            r_dip    <= n_dip;
            r_proto  <= n_proto;
            r_sport  <= n_sport;
            r_dport  <= n_dport;
            r_pstart <= n_pstart;
            r_pbytes <= n_pbytes;
        end
    end

    assign o_out_valid     = r_vld;
    assign o_parse_status  = r_status;
    assign o_frame_kind    = r_kind;
    assign o_dest_mac      = r_dmac;
    assign o_src_mac       = r_smac;
    assign o_ether_kind    = r_etype;
    assign o_src_ip        = r_sip;
    assign o_dst_ip        = r_dip;
    assign o_ip_protocol   = r_proto;
    assign o_src_port      = r_sport;
    assign o_dst_port      = r_dport;
    assign o_payload_start = r_pstart;
    assign o_payload_bytes = r_pbytes;

    // A short Ethernet frame carries nothing but its status.
    a_short_eth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_status == ST_SHORT_ETH) |->
        (r_kind == KIND_NON_IP && r_dmac == 48'd0 && r_etype == 16'd0))
        else $error("short frame reports header fields");

    // Transport fields only appear for a clean TCP or UDP frame.
    a_l4_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_pstart != 8'd0) |->
        (r_status == ST_OK && (r_kind == KIND_TCP || r_kind == KIND_UDP)))
        else $error("payload offset given for a failed or non-L4 frame");

    // Non-IPv4 frames report no IPv4 fields.
    a_non_ip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_kind == KIND_NON_IP) |-> (r_sip == 32'd0 && r_proto == 8'd0))
        else $error("IPv4 fields reported for a non-IPv4 frame");

endmodule

`default_nettype wire

[rtl/eth_ipv4_l4_header_parser.sv]
// Top level of the Ethernet / IPv4 / TCP-UDP header parser.
// Depends on eipl4_pkg, eipl4_capture and eipl4_judge.
//
// The parser takes one frame byte per beat, at most one beat per clock, from
// the destination MAC onwards, and gives one result beat for each byte that
// carries the end mark. Every byte is captured by its position in the frame;
// on the final byte the captured headers move into a snapshot register, and
// the checks run combinationally on that snapshot as it is loaded into the
// result register, which happens once that register is empty or its beat is
// taken. A full byte per clock is sustained, including a new frame straight
// after an end mark; the input stalls only while both the snapshot and the
// result register are held by a downstream that is not ready.
`default_nettype none

module eth_ipv4_l4_header_parser
    import eipl4_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_frame_byte,
    input  wire logic        i_end_of_frame,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_parse_status,
    output logic [1:0]       o_frame_kind,
    output logic [47:0]      o_dest_mac,
    output logic [47:0]      o_src_mac,
    output logic [15:0]      o_ether_kind,
    output logic [31:0]      o_src_ip,
    output logic [31:0]      o_dst_ip,
    output logic [7:0]       o_ip_protocol,
    output logic [15:0]      o_src_port,
    output logic [15:0]      o_dst_port,
    output logic [7:0]       o_payload_start,
    output logic [15:0]      o_payload_bytes
);

    logic      w_snap_vld;
    logic      w_snap_take;
    t_hdr_snap w_snap;

    // Field capture and frame snapshot.
    eipl4_capture u_capture (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_frame_byte   (i_frame_byte),
        .i_end_of_frame (i_end_of_frame),
        .o_snap_vld     (w_snap_vld),
        .o_snap         (w_snap),
        .i_snap_take    (w_snap_take)
    );

    // Header checks and result register.
    eipl4_judge u_judge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_snap_vld      (w_snap_vld),
        .i_snap          (w_snap),
        .o_snap_take     (w_snap_take),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_parse_status  (o_parse_status),
        .o_frame_kind    (o_frame_kind),
        .o_dest_mac      (o_dest_mac),
        .o_src_mac       (o_src_mac),
        .o_ether_kind    (o_ether_kind),
        .o_src_ip        (o_src_ip),
        .o_dst_ip        (o_dst_ip),
        .o_ip_protocol   (o_ip_protocol),
        .o_src_port      (o_src_port),
        .o_dst_port      (o_dst_port),
        .o_payload_start (o_payload_start),
        .o_payload_bytes (o_payload_bytes)
    );

endmodule

`default_nettype wire

[test/eth_ipv4_l4_header_parser_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for eth_ipv4_l4_header_parser, built on eipl4_pkg.
// Frames are assembled here byte by byte, a shadow of the header capture and checks
// predicts each result beat, and every result beat is compared field by field.

module eth_ipv4_l4_header_parser_test;
    import eipl4_pkg::*;

    localparam int DRAIN_CYCLES  = 8;
    localparam int RUN_LIMIT_NS  = 4_000_000;
    localparam int MAX_REPORTS   = 40;
    localparam int SAT_FRAME_LEN = 65540;

    // One result beat, in port order.
    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  kind;
        logic [47:0] dest_mac;
        logic [47:0] src_mac;
        logic [15:0] ether_kind;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [7:0]  protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  payload_start;
        logic [15:0] payload_bytes;
    } t_parse_result;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_frame_byte   = 8'h00;
    logic        i_end_of_frame = 1'b0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [3:0]  o_parse_status;
    logic [1:0]  o_frame_kind;
    logic [47:0] o_dest_mac;
    logic [47:0] o_src_mac;
    logic [15:0] o_ether_kind;
    logic [31:0] o_src_ip;
    logic [31:0] o_dst_ip;
    logic [7:0]  o_ip_protocol;
    logic [15:0] o_src_port;
    logic [15:0] o_dst_port;
    logic [7:0]  o_payload_start;
    logic [15:0] o_payload_bytes;

    int send_gap_pct    = 0;
    int ready_stall_pct = 0;
    int mismatch_count  = 0;

    // Headers captured so far in the current frame, and results still to come.
    t_hdr_snap     header_shadow = '0;
    t_parse_result pending_headers[$];
    logic [7:0]    frame_buf[$];

    eth_ipv4_l4_header_parser i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_frame_byte    (i_frame_byte),
        .i_end_of_frame  (i_end_of_frame),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_parse_status  (o_parse_status),
        .o_frame_kind    (o_frame_kind),
        .o_dest_mac      (o_dest_mac),
        .o_src_mac       (o_src_mac),
        .o_ether_kind    (o_ether_kind),
        .o_src_ip        (o_src_ip),
        .o_dst_ip        (o_dst_ip),
        .o_ip_protocol   (o_ip_protocol),
        .o_src_port      (o_src_port),
        .o_dst_port      (o_dst_port),
        .o_payload_start (o_payload_start),
        .o_payload_bytes (o_payload_bytes)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    // Stores one frame byte by its position, as the capture stage does.
    function automatic void capture_byte(input logic [7:0] b);
        int unsigned pos;
        int unsigned l4_base;
        int unsigned rel;
        pos = header_shadow.len;
        if (pos < POS_SRC_MAC) begin
            header_shadow.dest_mac = {header_shadow.dest_mac[39:0], b};
        end else if (pos < POS_ETYPE) begin
            header_shadow.src_mac = {header_shadow.src_mac[39:0], b};
        end else if (pos < POS_VIHL) begin
            header_shadow.ether_kind = {header_shadow.ether_kind[7:0], b};
        end else if (pos == POS_VIHL) begin
            header_shadow.version_ihl = b;
        end else if (pos == POS_TLEN_HI || pos == POS_TLEN_LO) begin
            header_shadow.total_len = {header_shadow.total_len[7:0], b};
        end else if (pos == POS_PROTO) begin
            header_shadow.protocol = b;
        end else if (pos >= POS_SRC_IP && pos < POS_DST_IP) begin
            header_shadow.src_ip = {header_shadow.src_ip[23:0], b};
        end else if (pos >= POS_DST_IP && pos < POS_L4_MIN) begin
            header_shadow.dst_ip = {header_shadow.dst_ip[23:0], b};
        end

        // The transport header sits where IHL says, never before a minimum IPv4 header ends.
        l4_base = ETH_HDR_LEN + 4 * (header_shadow.version_ihl & IHL_MASK);
        if (pos >= POS_L4_MIN && pos >= l4_base) begin
            rel = pos - l4_base;
            if (rel < L4_DST_PORT) begin
                header_shadow.src_port = {header_shadow.src_port[7:0], b};
            end else if (rel < L4_UDP_LEN) begin
                header_shadow.dst_port = {header_shadow.dst_port[7:0], b};
            end else if (rel < L4_UDP_END) begin
                header_shadow.udp_len = {header_shadow.udp_len[7:0], b};
            end else if (rel == L4_TCP_OFF) begin
                header_shadow.tcp_offset = b[7:4];
            end
        end

        // The byte counter saturates rather than wrapping.
        if (header_shadow.len != CNT_MAX) begin
            header_shadow.len = header_shadow.len + 16'd1;
        end
    endfunction

    // Runs the checks in order on the captured headers; the first failing check decides.
    function automatic t_parse_result predict_result();
        t_parse_result r;
        int unsigned   len;
        int unsigned   hlen;
        int unsigned   l4_base;
        int unsigned   in_frame;
        int unsigned   ip_end;
        int unsigned   thlen;
        r = '0;
        len = header_shadow.len;
        if (len < ETH_HDR_LEN) begin
            r.status = ST_SHORT_ETH;
            return r;
        end
        r.dest_mac   = header_shadow.dest_mac;
        r.src_mac    = header_shadow.src_mac;
        r.ether_kind = header_shadow.ether_kind;
        if (header_shadow.ether_kind != ETHERTYPE_IPV4) begin
            return r;
        end

        // IPv4 header checks.
        r.kind = KIND_IP;
        if (len < ETH_HDR_LEN + IP_MIN_HDR) begin
            r.status = ST_SHORT_IP;
            return r;
        end
        if (header_shadow.version_ihl[7:4] != IP_VERSION_4) begin
            r.status = ST_BAD_VERSION;
            return r;
        end
        hlen = 4 * (header_shadow.version_ihl & IHL_MASK);
        if (hlen < IP_MIN_HDR || len < ETH_HDR_LEN + hlen) begin
            r.status = ST_BAD_IHL;
            return r;
        end
        if (header_shadow.total_len < hlen) begin
            r.status = ST_TOTAL_SHORT;
            return r;
        end
        r.src_ip   = header_shadow.src_ip;
        r.dst_ip   = header_shadow.dst_ip;
        r.protocol = header_shadow.protocol;

        // The datagram ends at the total length or at the end of the frame, whichever is first.
        l4_base  = ETH_HDR_LEN + hlen;
        in_frame = (header_shadow.total_len <= len - ETH_HDR_LEN) ?
                   header_shadow.total_len : len - ETH_HDR_LEN;
        ip_end   = ETH_HDR_LEN + in_frame;

        if (header_shadow.protocol == PROTO_TCP) begin
            r.kind = KIND_TCP;
            if (len < l4_base + TCP_MIN_HDR) begin
                r.status = ST_SHORT_TCP;
                return r;
            end
            thlen = 4 * header_shadow.tcp_offset;
            if (thlen < TCP_MIN_HDR || len < l4_base + thlen) begin
                r.status = ST_BAD_TCP_OFF;
                return r;
            end
            if (l4_base + thlen > ip_end) begin
                r.status = ST_TCP_PAST_IP;
                return r;
            end
            r.src_port      = header_shadow.src_port;
            r.dst_port      = header_shadow.dst_port;
            r.payload_start = 8'(l4_base + thlen);
            r.payload_bytes = 16'(ip_end - (l4_base + thlen));
        end else if (header_shadow.protocol == PROTO_UDP) begin
            r.kind = KIND_UDP;
            if (len < l4_base + UDP_HDR_LEN) begin
                r.status = ST_SHORT_UDP;
                return r;
            end
            if (header_shadow.udp_len < UDP_HDR_LEN ||
                l4_base + header_shadow.udp_len > ip_end) begin
                r.status = ST_BAD_UDP_LEN;
                return r;
            end
            r.src_port      = header_shadow.src_port;
            r.dst_port      = header_shadow.dst_port;
            r.payload_start = 8'(l4_base + UDP_HDR_LEN);
            r.payload_bytes = 16'(header_shadow.udp_len - UDP_HDR_LEN);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t ns: mismatch, %s", $time, msg);
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    task automatic check_result(input t_parse_result got);
        t_parse_result want;
        if (pending_headers.size() == 0) begin
            report_mismatch($sformatf("result beat with no frame pending, status %0d",
                                      got.status));
        end else begin
            want = pending_headers.pop_front();
            compare_field("parse_status",  got.status,        want.status);
            compare_field("frame_kind",    got.kind,          want.kind);
            compare_field("dest_mac",      got.dest_mac,      want.dest_mac);
            compare_field("src_mac",       got.src_mac,       want.src_mac);
            compare_field("ether_kind",    got.ether_kind,    want.ether_kind);
            compare_field("src_ip",        got.src_ip,        want.src_ip);
            compare_field("dst_ip",        got.dst_ip,        want.dst_ip);
            compare_field("ip_protocol",   got.protocol,      want.protocol);
            compare_field("src_port",      got.src_port,      want.src_port);
            compare_field("dst_port",      got.dst_port,      want.dst_port);
            compare_field("payload_start", got.payload_start, want.payload_start);
            compare_field("payload_bytes", got.payload_bytes, want.payload_bytes);
        end
    endtask

    // Result side: check each accepted beat, then choose the next ready at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_result({o_parse_status, o_frame_kind, o_dest_mac, o_src_mac, o_ether_kind,
                          o_src_ip, o_dst_ip, o_ip_protocol, o_src_port, o_dst_port,
                          o_payload_start, o_payload_bytes});
        end
        i_out_ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // ---------------------------------------------------------------- frame building

    function automatic void fill_frame(input int len, input bit random_bytes,
                                       input logic [7:0] value);
        frame_buf.delete();
        repeat (len) frame_buf.push_back(random_bytes ? 8'($urandom) : value);
    endfunction

    function automatic void put16(input int pos, input logic [15:0] value);
        if (pos + 1 < frame_buf.size()) begin
            frame_buf[pos]     = value[15:8];
            frame_buf[pos + 1] = value[7:0];
        end
    endfunction

    function automatic void truncate_frame(input int len);
        while (frame_buf.size() > len) frame_buf.pop_back();
    endfunction

    // Ethernet padding behind the IPv4 datagram.
    function automatic void pad_frame(input int count);
        repeat (count) frame_buf.push_back(8'($urandom));
    endfunction

    function automatic void set_tcp_offset(input int ihl, input logic [3:0] doff);
        int idx;
        idx = ETH_HDR_LEN + 4 * ihl + L4_TCP_OFF;
        if (idx < frame_buf.size()) begin
            frame_buf[idx] = {doff, frame_buf[idx][3:0]};
        end
    endfunction

    // A consistent IPv4 frame with random addresses, options and payload. An IHL below
    // five still leaves room for a minimum header so that later checks have bytes to see.
    function automatic void build_ipv4(input logic [7:0] proto, input int ihl,
                                       input int l4_hdr, input int pay_len);
        int         hdr;
        logic [3:0] ihl_nib;
        logic [3:0] doff;
        hdr     = (ihl >= 5) ? 4 * ihl : IP_MIN_HDR;
        ihl_nib = 4'(ihl);
        doff    = 4'(l4_hdr / 4);
        fill_frame(ETH_HDR_LEN + hdr + l4_hdr + pay_len, 1'b1, 8'h00);
        put16(POS_ETYPE, ETHERTYPE_IPV4);
        frame_buf[POS_VIHL] = {IP_VERSION_4, ihl_nib};
        put16(POS_TLEN_HI, 16'(hdr + l4_hdr + pay_len));
        frame_buf[POS_PROTO] = proto;
        if (proto == PROTO_TCP && l4_hdr > L4_TCP_OFF) begin
            set_tcp_offset(hdr / 4, doff);
        end
        if (proto == PROTO_UDP) begin
            put16(ETH_HDR_LEN + hdr + L4_UDP_LEN, 16'(UDP_HDR_LEN + pay_len));
        end
    endfunction

    // ---------------------------------------------------------------- driving

    // Offers one byte beat and waits until it is taken; valid stays high afterwards
    // so that a following beat can go out without a gap.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_frame_byte   <= value;
        i_end_of_frame <= is_last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        capture_byte(value);
        if (is_last) begin
            pending_headers.push_back(predict_result());
            header_shadow = '0;
        end
    endtask

    task automatic send_frame();
        foreach (frame_buf[k]) send_byte(frame_buf[k], k == frame_buf.size() - 1);
    endtask

    // Holds the input off until every pending result has been seen.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_headers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_short_frames();
        // End mark on the very first byte.
        fill_frame(1, 1'b1, 8'h00);
        send_frame();
        fill_frame(13, 1'b0, 8'hff);
        send_frame();
        // A bare Ethernet header announcing IPv4.
        fill_frame(14, 1'b1, 8'h00);
        put16(POS_ETYPE, ETHERTYPE_IPV4);
        send_frame();
        fill_frame(14, 1'b0, 8'h00);
        send_frame();
        wait_drain();
    endtask

    task automatic test_non_ipv4();
        fill_frame(64, 1'b0, 8'hff);
        send_frame();
        fill_frame(60, 1'b1, 8'h00);
        put16(POS_ETYPE, 16'h86dd);
        send_frame();
        wait_drain();
    endtask

    task automatic test_ipv4_header_errors();
        build_ipv4(PROTO_TCP, 5, TCP_MIN_HDR, 10);
        truncate_frame(ETH_HDR_LEN + IP_MIN_HDR - 1);
        send_frame();
        build_ipv4(PROTO_UDP, 5, UDP_HDR_LEN, 4);
        frame_buf[POS_VIHL] = {4'd6, 4'd5};
        send_frame();
        build_ipv4(PROTO_UDP, 15, UDP_HDR_LEN, 4);
        frame_buf[POS_VIHL] = 8'hff;
        send_frame();
        // IHL of zero and of four.
        build_ipv4(PROTO_TCP, 0, TCP_MIN_HDR, 4);
        send_frame();
        build_ipv4(PROTO_TCP, 4, TCP_MIN_HDR, 4);
        send_frame();
        // Largest IHL with the frame one byte short of the options.
        build_ipv4(8'd1, 15, 0, 0);
        truncate_frame(ETH_HDR_LEN + 59);
        send_frame();
        // Total length below the header length.
        build_ipv4(PROTO_TCP, 5, TCP_MIN_HDR, 4);
        put16(POS_TLEN_HI, IP_MIN_HDR - 1);
        send_frame();
        wait_drain();
    endtask

    task automatic test_other_protocol();
        build_ipv4(8'd1, 15, 8, 10);
        send_frame();
        // Total length claims far more than the frame holds.
        build_ipv4(8'hff, 5, 0, 6);
        put16(POS_TLEN_HI, 16'hffff);
        send_frame();
        wait_drain();
    endtask

    task automatic test_tcp_frames();
        build_ipv4(PROTO_TCP, 5, TCP_MIN_HDR, 0);
        send_frame();
        // Largest IP and TCP headers: the payload starts as late as it can.
        build_ipv4(PROTO_TCP, 15, 60, 20);
        send_frame();
        build_ipv4(PROTO_TCP, 5, TCP_MIN_HDR, 0);
        truncate_frame(ETH_HDR_LEN + IP_MIN_HDR + TCP_MIN_HDR - 1);
        send_frame();
        build_ipv4(PROTO_TCP, 5, TCP_MIN_HDR, 8);
        set_tcp_offset(5, 4'd4);
        send_frame();
        // Data offset reaches past the end of the frame.
        build_ipv4(PROTO_TCP, 5, TCP_MIN_HDR, 20);
        set_tcp_offset(5, 4'd15);
        send_frame();
        // TCP header runs past the end of the IPv4 datagram.
        build_ipv4(PROTO_TCP, 5, TCP_MIN_HDR, 10);
        put16(POS_TLEN_HI, 16'd39);
        send_frame();
        build_ipv4(PROTO_TCP, 5, TCP_MIN_HDR, 6);
        pad_frame(10);
        send_frame();
        wait_drain();
    endtask

    task automatic test_udp_frames();
        build_ipv4(PROTO_UDP, 5, UDP_HDR_LEN, 0);
        send_frame();
        build_ipv4(PROTO_UDP, 5, UDP_HDR_LEN, 0);
        truncate_frame(ETH_HDR_LEN + IP_MIN_HDR + UDP_HDR_LEN - 1);
        send_frame();
        build_ipv4(PROTO_UDP, 5, UDP_HDR_LEN, 10);
        put16(ETH_HDR_LEN + IP_MIN_HDR + L4_UDP_LEN, UDP_HDR_LEN - 1);
        send_frame();
        build_ipv4(PROTO_UDP, 5, UDP_HDR_LEN, 10);
        put16(ETH_HDR_LEN + IP_MIN_HDR + L4_UDP_LEN, 16'hffff);
        send_frame();
        build_ipv4(PROTO_UDP, 15, UDP_HDR_LEN, 30);
        pad_frame(8);
        send_frame();
        wait_drain();
    endtask

    // Mostly well-formed frames with random content; the rest are cut short, corrupted
    // in one header byte or field, carry another EtherType, or are plain noise.
    task automatic send_random_frame();
        int         pick;
        int         ihl;
        int         l4_hdr;
        int         pay;
        int         mode;
        int         idx;
        logic [7:0] proto;
        pick = $urandom_range(99);
        ihl  = ($urandom_range(3) == 0) ? $urandom_range(15, 6) : 5;
        pay  = $urandom_range(40);
        if (pick < 45) begin
            proto  = PROTO_TCP;
            l4_hdr = 4 * (($urandom_range(2) == 0) ? $urandom_range(15, 6) : 5);
        end else if (pick < 80) begin
            proto  = PROTO_UDP;
            l4_hdr = UDP_HDR_LEN;
        end else begin
            proto  = 8'($urandom);
            l4_hdr = $urandom_range(20);
        end
        build_ipv4(proto, ihl, l4_hdr, pay);

        mode = $urandom_range(99);
        if (mode < 60) begin
            if ($urandom_range(2) == 0) begin
                pad_frame($urandom_range(12, 1));
            end
        end else if (mode < 70) begin
            truncate_frame($urandom_range(frame_buf.size(), 1));
        end else if (mode < 78) begin
            idx = $urandom_range(ETH_HDR_LEN + 4 * ihl + l4_hdr - 1, POS_ETYPE);
            frame_buf[idx] = 8'($urandom);
        end else if (mode < 86) begin
            case ($urandom_range(2))
                0: put16(POS_TLEN_HI, 16'($urandom_range(4 * ihl + l4_hdr + pay + 8)));
                1: put16(ETH_HDR_LEN + 4 * ihl + L4_UDP_LEN, 16'($urandom_range(pay + 16)));
                default: set_tcp_offset(ihl, 4'($urandom));
            endcase
        end else if (mode < 93) begin
            put16(POS_ETYPE, 16'($urandom));
        end else begin
            fill_frame($urandom_range(90, 1), 1'b1, 8'h00);
        end
        send_frame();
    endtask

    task automatic test_random_frames(input int count);
        repeat (count) send_random_frame();
        wait_drain();
    endtask

    // A frame longer than the byte counter can count, then a normal one to show
    // that the counter starts again from zero.
    task automatic test_counter_saturation();
        build_ipv4(PROTO_TCP, 5, TCP_MIN_HDR,
                   SAT_FRAME_LEN - (ETH_HDR_LEN + IP_MIN_HDR + TCP_MIN_HDR));
        put16(POS_TLEN_HI, CNT_MAX);
        send_frame();
        build_ipv4(PROTO_UDP, 5, UDP_HDR_LEN, 4);
        send_frame();
        wait_drain();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender gaps with a mostly stalled receiver.
        send_gap_pct    = 32;
        ready_stall_pct = 75;
        test_short_frames();
        test_non_ipv4();
        test_ipv4_header_errors();
        test_other_protocol();
        test_tcp_frames();
        test_udp_frames();
        test_random_frames(20);

        // Mostly idle sender, occasional receiver stalls.
        send_gap_pct    = 75;
        ready_stall_pct = 32;
        test_random_frames(20);

        // Full rate on both sides.
        send_gap_pct    = 0;
        ready_stall_pct = 0;
        test_random_frames(20);
        test_counter_saturation();

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
